/* design/qpps_pkg.sv */
// ----------------------------------------------------------------------------
// qpps_pkg: shared definitions for the quadrature PID position servo
// Register map codes, reset values, count modes, word codes and field widths.
// ----------------------------------------------------------------------------
package qpps_pkg;

    // default sizes handed to the top level parameters
    localparam int COUNT_BITS_DEF = 32;
    localparam int SUM_BITS_DEF   = 48;
    localparam int DUTY_BITS_DEF  = 10;

    // fixed field widths
    localparam int GAIN_BITS   = 32;
    localparam int ERR_BITS    = 32;
    localparam int CHG_BITS    = 33;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_CNT_BITS = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    // register indices, byte address is 4 times the index
    localparam logic [REG_IDX_BITS-1:0] REG_COUNT_MODE   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_TARGET_COUNT = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_P       = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_I       = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_D       = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_DUTY_LIMIT   = 3'd5;

    // register reset values
    localparam logic [1:0]                  COUNT_MODE_RESET   = 2'd2;
    localparam logic signed [GAIN_BITS-1:0] TARGET_COUNT_RESET = 32'sd1080;
    localparam logic signed [GAIN_BITS-1:0] GAIN_P_RESET       = 32'sd182044;
    localparam logic signed [GAIN_BITS-1:0] GAIN_I_RESET       = 32'sd15;
    localparam logic signed [GAIN_BITS-1:0] GAIN_D_RESET       = 32'sd151704;
    localparam int                          DUTY_LIMIT_RESET   = 100;

    // count modes
    localparam logic [1:0] MODE_RISE_A  = 2'd0;
    localparam logic [1:0] MODE_BOTH_A  = 2'd1;
    localparam logic [1:0] MODE_BOTH_AB = 2'd2;

    // word codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // error saturation bounds
    localparam logic signed [ERR_BITS-1:0] ERR_MAX = 32'sh7fff_ffff;
    localparam logic signed [ERR_BITS-1:0] ERR_MIN = 32'sh8000_0000;

    // loop gains as one group
    typedef struct packed {
        logic signed [GAIN_BITS-1:0] gain_p;
        logic signed [GAIN_BITS-1:0] gain_i;
        logic signed [GAIN_BITS-1:0] gain_d;
    } gains_t;

endpackage

/* design/qpps_encoder.sv */
// ----------------------------------------------------------------------------
// qpps_encoder: quadrature decoder and position counter
// Compares each pin sample with the latched levels and moves the count by one
// according to the selected 1X, 2X or 4X counting mode.
// ----------------------------------------------------------------------------
module qpps_encoder #(
    parameter int COUNT_BITS = qpps_pkg::COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample,
    input  logic                         pin_a,
    input  logic                         pin_b,
    input  logic [1:0]                   count_mode,
    output logic signed [COUNT_BITS-1:0] count,
    output logic signed [COUNT_BITS-1:0] count_next
);
    import qpps_pkg::*;

    logic                  last_a_reg;
    logic                  last_b_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  a_chg;
    logic                  b_chg;
    logic                  move;
    logic                  up;

    assign a_chg = pin_a ^ last_a_reg;
    assign b_chg = pin_b ^ last_b_reg;

    // direction decode per mode
    always_comb
    begin
        move = 1'b0;
        up   = 1'b0;
        case (count_mode)
            MODE_RISE_A:
            begin
                move = a_chg & pin_a;
                up   = pin_b;
            end
            MODE_BOTH_A:
            begin
                move = a_chg;
                up   = ~(pin_a ^ pin_b);
            end
            MODE_BOTH_AB:
            begin
                // simultaneous changes on both pins cancel
                move = a_chg ^ b_chg;
                up   = a_chg ? ~(pin_a ^ pin_b) : (pin_a ^ pin_b);
            end
            default:
            begin
                move = 1'b0;
                up   = 1'b0;
            end
        endcase
    end

    // count after this word, wraps within the counter width
    always_comb
    begin
        count_next = count_reg;
        if (sample && move)
        begin
            count_next = up ? count_reg + COUNT_BITS'(1'b1)
                            : count_reg - COUNT_BITS'(1'b1);
        end
    end

    assign count = count_reg;

    // pin latch and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (sample)
        begin
            last_a_reg <= pin_a;
            last_b_reg <= pin_b;
            count_reg  <= count_next;
        end
    end

    // count holds when no sample arrives
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !sample |=> $stable(count_reg))
        else $error("count moved without a pin sample");

    // in 4x mode a double change cancels
    a_double_change: assert property (@(posedge clk) disable iff (!rst_n)
        (sample && count_mode == MODE_BOTH_AB && a_chg && b_chg) |=> $stable(count_reg))
        else $error("count moved on a simultaneous A and B change");

endmodule

/* design/qpps_error.sv */
// ----------------------------------------------------------------------------
// qpps_error: position error and PID history
// Forms the saturated error on a tick and keeps the error sum, the error
// change and the previous error; presents the history from the last tick.
// ----------------------------------------------------------------------------
module qpps_error #(
    parameter int COUNT_BITS = qpps_pkg::COUNT_BITS_DEF,
    parameter int SUM_BITS   = qpps_pkg::SUM_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   tick,
    input  logic signed [qpps_pkg::GAIN_BITS-1:0]  target_count,
    input  logic signed [COUNT_BITS-1:0]           count,
    output logic signed [qpps_pkg::ERR_BITS-1:0]   err,
    output logic signed [SUM_BITS-1:0]             sum_old,
    output logic signed [qpps_pkg::CHG_BITS-1:0]   chg_old
);
    import qpps_pkg::*;

    // wide enough for the difference of the target and the count
    localparam int WIDE_BITS = (COUNT_BITS > GAIN_BITS) ? COUNT_BITS : GAIN_BITS;
    localparam int DIFF_BITS = WIDE_BITS + 2;

    logic signed [SUM_BITS-1:0]  error_sum_reg;
    logic signed [SUM_BITS-1:0]  error_sum_next;
    logic signed [CHG_BITS-1:0]  error_change_reg;
    logic signed [CHG_BITS-1:0]  error_change_next;
    logic signed [ERR_BITS-1:0]  prev_error_reg;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [SUM_BITS:0]    sum_ext;
    logic                        diff_in_range;

    // reference minus count, saturated to 32 bits
    assign diff = DIFF_BITS'(target_count) - DIFF_BITS'(count);
    assign diff_in_range = (&diff[DIFF_BITS-1:ERR_BITS-1]) | ~(|diff[DIFF_BITS-1:ERR_BITS-1]);

    always_comb
    begin
        if (diff_in_range)
        begin
            err = diff[ERR_BITS-1:0];
        end
        else
        begin
            err = diff[DIFF_BITS-1] ? ERR_MIN : ERR_MAX;
        end
    end

    // saturating accumulate
    assign sum_ext = (SUM_BITS + 1)'(error_sum_reg) + (SUM_BITS + 1)'(err);

    always_comb
    begin
        if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1])
        begin
            error_sum_next = sum_ext[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                               : {1'b0, {(SUM_BITS - 1){1'b1}}};
        end
        else
        begin
            error_sum_next = sum_ext[SUM_BITS-1:0];
        end
    end

    assign error_change_next = CHG_BITS'(err) - CHG_BITS'(prev_error_reg);

    assign sum_old = error_sum_reg;
    assign chg_old = error_change_reg;

    // history update on each tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg    <= '0;
            error_change_reg <= '0;
            prev_error_reg   <= '0;
        end
        else if (tick)
        begin
            error_sum_reg    <= error_sum_next;
            error_change_reg <= error_change_next;
            prev_error_reg   <= err;
        end
    end

    // history only moves on a tick
    a_history_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> ($stable(prev_error_reg) && $stable(error_sum_reg)))
        else $error("pid history changed without a tick");

endmodule

/* design/qpps_pid_pipe.sv */
// ----------------------------------------------------------------------------
// qpps_pid_pipe: PID output pipeline
// Carries every word from the input register to the result register: partial
// products, sums, magnitude, then saturation and forward/reverse selection.
// ----------------------------------------------------------------------------
module qpps_pid_pipe #(
    parameter int COUNT_BITS = qpps_pkg::COUNT_BITS_DEF,
    parameter int SUM_BITS   = qpps_pkg::SUM_BITS_DEF,
    parameter int DUTY_BITS  = qpps_pkg::DUTY_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic                                         op,
    input  logic signed [COUNT_BITS-1:0]                 count_next,
    input  logic signed [qpps_pkg::ERR_BITS-1:0]         err,
    input  logic signed [SUM_BITS-1:0]                   sum_old,
    input  logic signed [qpps_pkg::CHG_BITS-1:0]         chg_old,
    input  qpps_pkg::gains_t                             gains,
    input  logic [DUTY_BITS-1:0]                         duty_limit,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic signed [qpps_pkg::OUT_CNT_BITS-1:0]     count_now,
    output logic [DUTY_BITS-1:0]                         duty_forward,
    output logic [DUTY_BITS-1:0]                         duty_reverse
);
    import qpps_pkg::*;

    localparam int LO_BITS   = SUM_BITS / 2;
    localparam int HI_BITS   = SUM_BITS - LO_BITS;
    localparam int PP_P_BITS = GAIN_BITS + ERR_BITS;
    localparam int PP_D_BITS = GAIN_BITS + CHG_BITS;
    localparam int PP_IL_BITS = GAIN_BITS + LO_BITS + 1;
    localparam int PP_IH_BITS = GAIN_BITS + HI_BITS;
    localparam int SUM_A_BITS = PP_D_BITS + 1;
    localparam int U_BITS    = SUM_BITS + GAIN_BITS + 2;
    localparam int MAG_BITS  = U_BITS - FRAC_BITS;

    // stage valids and ready chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

    // stage payloads
    logic                          s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg, s5_op_reg;
    logic                          s1_pos_reg, s2_pos_reg, s3_pos_reg, s4_pos_reg, s5_pos_reg;
    logic signed [COUNT_BITS-1:0]  s1_cnt_reg, s2_cnt_reg, s3_cnt_reg, s4_cnt_reg, s5_cnt_reg;
    logic signed [ERR_BITS-1:0]    s1_err_reg;
    logic signed [SUM_BITS-1:0]    s1_sum_reg;
    logic signed [CHG_BITS-1:0]    s1_chg_reg;
    logic signed [PP_P_BITS-1:0]   s2_pp_p_reg;
    logic signed [PP_D_BITS-1:0]   s2_pp_d_reg;
    logic signed [PP_IL_BITS-1:0]  s2_pp_il_reg;
    logic signed [PP_IH_BITS-1:0]  s2_pp_ih_reg;
    logic signed [SUM_A_BITS-1:0]  s3_sum_a_reg;
    logic signed [U_BITS-1:0]      s3_sum_b_reg;
    logic signed [U_BITS-1:0]      s4_u_reg;
    logic [MAG_BITS-1:0]           s5_mag_reg;
    logic signed [OUT_CNT_BITS-1:0] count_now_reg;
    logic [DUTY_BITS-1:0]          held_forward_reg;
    logic [DUTY_BITS-1:0]          held_reverse_reg;

    // combinational values between stages
    logic signed [PP_P_BITS-1:0]   pp_p_next;
    logic signed [PP_D_BITS-1:0]   pp_d_next;
    logic signed [PP_IL_BITS-1:0]  pp_il_next;
    logic signed [PP_IH_BITS-1:0]  pp_ih_next;
    logic signed [SUM_A_BITS-1:0]  sum_a_next;
    logic signed [U_BITS-1:0]      sum_b_next;
    logic signed [U_BITS-1:0]      u_next;
    logic [U_BITS-1:0]             u_abs;
    logic [DUTY_BITS-1:0]          mag_sat;
    logic signed [63:0]            cnt_wide;

    // a stage takes a word when it is empty or its word moves on
    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy5     = !s5_valid_reg || rdy_out;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // stage 1: operands captured with the word
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_op_reg  <= op;
            s1_pos_reg <= !err[ERR_BITS-1] && (err != '0);
            s1_cnt_reg <= count_next;
            s1_err_reg <= err;
            s1_sum_reg <= sum_old;
            s1_chg_reg <= chg_old;
        end
    end

    // stage 2: partial products, integral term split in two halves
    assign pp_p_next  = gains.gain_p * s1_err_reg;
    assign pp_d_next  = gains.gain_d * s1_chg_reg;
    assign pp_il_next = gains.gain_i * $signed({1'b0, s1_sum_reg[LO_BITS-1:0]});
    assign pp_ih_next = gains.gain_i * $signed(s1_sum_reg[SUM_BITS-1:LO_BITS]);

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_pos_reg   <= s1_pos_reg;
            s2_cnt_reg   <= s1_cnt_reg;
            s2_pp_p_reg  <= pp_p_next;
            s2_pp_d_reg  <= pp_d_next;
            s2_pp_il_reg <= pp_il_next;
            s2_pp_ih_reg <= pp_ih_next;
        end
    end

    // stage 3: pairwise sums
    assign sum_a_next = SUM_A_BITS'(s2_pp_p_reg) + SUM_A_BITS'(s2_pp_d_reg);
    assign sum_b_next = (U_BITS'(s2_pp_ih_reg) <<< LO_BITS) + U_BITS'(s2_pp_il_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_pos_reg   <= s2_pos_reg;
            s3_cnt_reg   <= s2_cnt_reg;
            s3_sum_a_reg <= sum_a_next;
            s3_sum_b_reg <= sum_b_next;
        end
    end

    // stage 4: full control effort, signed with 16 fraction bits (Q66.16 at default widths)
    assign u_next = U_BITS'(s3_sum_a_reg) + s3_sum_b_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_op_reg  <= s3_op_reg;
            s4_pos_reg <= s3_pos_reg;
            s4_cnt_reg <= s3_cnt_reg;
            s4_u_reg   <= u_next;
        end
    end

    // stage 5: magnitude, fraction dropped
    assign u_abs = s4_u_reg[U_BITS-1] ? (~s4_u_reg + U_BITS'(1'b1)) : s4_u_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            s5_op_reg  <= s4_op_reg;
            s5_pos_reg <= s4_pos_reg;
            s5_cnt_reg <= s4_cnt_reg;
            s5_mag_reg <= u_abs[U_BITS-1:FRAC_BITS];
        end
    end

    // result stage: saturate to the pwm range and pick the drive line
    always_comb
    begin
        if (s5_mag_reg > {{(MAG_BITS - DUTY_BITS){1'b0}}, duty_limit})
        begin
            mag_sat = duty_limit;
        end
        else
        begin
            mag_sat = s5_mag_reg[DUTY_BITS-1:0];
        end
    end

    assign cnt_wide = 64'(s5_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (rdy_out && s5_valid_reg)
        begin
            count_now_reg <= cnt_wide[OUT_CNT_BITS-1:0];
        end
    end

    // held duties double as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_forward_reg <= '0;
            held_reverse_reg <= '0;
        end
        else if (rdy_out && s5_valid_reg && s5_op_reg == OP_TICK)
        begin
            held_forward_reg <= s5_pos_reg ? mag_sat : '0;
            held_reverse_reg <= s5_pos_reg ? '0 : mag_sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign count_now    = count_now_reg;
    assign duty_forward = held_forward_reg;
    assign duty_reverse = held_reverse_reg;

    // only one drive line is ever active
    a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
        !((|held_forward_reg) && (|held_reverse_reg)))
        else $error("forward and reverse duty both active");

endmodule

/* design/quadrature_pid_position_servo.sv */
// ----------------------------------------------------------------------------
// quadrature_pid_position_servo: encoder counter with PID position drive
// Each input word is a pin sample (op 0) or a control tick (op 1) and gives
// exactly one result word: the position count after the word and the
// forward/reverse duties, which hold their values between ticks.
// Input channel: in_valid/in_ready with op, pin_a, pin_b. Output channel:
// out_valid/out_ready with count_now, duty_forward, duty_reverse.
// Pipeline: a word accepted at a rising edge passes through six pipeline
// registers: input capture, partial products, pairwise sums, full sum,
// magnitude, result. Throughput is one word per clock while out_ready stays
// high; the count and PID history are updated at the accepting edge.
// When the receiver stalls, the pipeline keeps taking words until every
// stage is full, then in_ready drops; no word is lost or repeated.
// Registers (APB, byte address 4*index): count_mode, target_count, gain_p,
// gain_i, gain_d, duty_limit; write them only while no word is in flight.
// Reset clears the count, pin latches, history and duties and loads the
// register reset values; there is no clearing pass.
// ----------------------------------------------------------------------------
module quadrature_pid_position_servo #(
    parameter int COUNT_BITS = qpps_pkg::COUNT_BITS_DEF,
    parameter int SUM_BITS   = qpps_pkg::SUM_BITS_DEF,
    parameter int DUTY_BITS  = qpps_pkg::DUTY_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // apb configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [qpps_pkg::APB_ADDR_BITS-1:0]        paddr,
    input  logic [qpps_pkg::APB_DATA_BITS-1:0]        pwdata,
    output logic [qpps_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                      pready,
    // input words
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      op,
    input  logic                                      pin_a,
    input  logic                                      pin_b,
    // result words
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [qpps_pkg::OUT_CNT_BITS-1:0]  count_now,
    output logic [DUTY_BITS-1:0]                      duty_forward,
    output logic [DUTY_BITS-1:0]                      duty_reverse
);
    import qpps_pkg::*;

    logic [1:0]                   count_mode_reg;
    logic signed [GAIN_BITS-1:0]  target_count_reg;
    logic signed [GAIN_BITS-1:0]  gain_p_reg;
    logic signed [GAIN_BITS-1:0]  gain_i_reg;
    logic signed [GAIN_BITS-1:0]  gain_d_reg;
    logic [DUTY_BITS-1:0]         duty_limit_reg;
    logic                         cfg_write;
    logic [REG_IDX_BITS-1:0]      reg_idx;
    gains_t                       gains;

    logic                         accept;
    logic                         sample;
    logic                         tick;
    logic signed [COUNT_BITS-1:0] count;
    logic signed [COUNT_BITS-1:0] count_next;
    logic signed [ERR_BITS-1:0]   err;
    logic signed [SUM_BITS-1:0]   sum_old;
    logic signed [CHG_BITS-1:0]   chg_old;

    // register file
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg   <= COUNT_MODE_RESET;
            target_count_reg <= TARGET_COUNT_RESET;
            gain_p_reg       <= GAIN_P_RESET;
            gain_i_reg       <= GAIN_I_RESET;
            gain_d_reg       <= GAIN_D_RESET;
            duty_limit_reg   <= DUTY_BITS'(DUTY_LIMIT_RESET);
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_COUNT_MODE:   count_mode_reg   <= pwdata[1:0];
                REG_TARGET_COUNT: target_count_reg <= pwdata;
                REG_GAIN_P:       gain_p_reg       <= pwdata;
                REG_GAIN_I:       gain_i_reg       <= pwdata;
                REG_GAIN_D:       gain_d_reg       <= pwdata;
                REG_DUTY_LIMIT:   duty_limit_reg   <= pwdata[DUTY_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_COUNT_MODE:   prdata = APB_DATA_BITS'(count_mode_reg);
            REG_TARGET_COUNT: prdata = target_count_reg;
            REG_GAIN_P:       prdata = gain_p_reg;
            REG_GAIN_I:       prdata = gain_i_reg;
            REG_GAIN_D:       prdata = gain_d_reg;
            REG_DUTY_LIMIT:   prdata = APB_DATA_BITS'(duty_limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign gains.gain_p = gain_p_reg;
    assign gains.gain_i = gain_i_reg;
    assign gains.gain_d = gain_d_reg;

    // word decode at the accepting edge
    assign accept = in_valid && in_ready;
    assign sample = accept && (op == OP_SAMPLE);
    assign tick   = accept && (op == OP_TICK);

    qpps_encoder #(
        .COUNT_BITS (COUNT_BITS)
    ) u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .pin_a      (pin_a),
        .pin_b      (pin_b),
        .count_mode (count_mode_reg),
        .count      (count),
        .count_next (count_next)
    );

    qpps_error #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_error (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .target_count (target_count_reg),
        .count        (count),
        .err          (err),
        .sum_old      (sum_old),
        .chg_old      (chg_old)
    );

    qpps_pid_pipe #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_BITS   (SUM_BITS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_pid_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .count_next   (count_next),
        .err          (err),
        .sum_old      (sum_old),
        .chg_old      (chg_old),
        .gains        (gains),
        .duty_limit   (duty_limit_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .count_now    (count_now),
        .duty_forward (duty_forward),
        .duty_reverse (duty_reverse)
    );

endmodule
